@@ rtl/assert_macros.svh @@
// assertion helpers for the rtl files, included by tss_back
// every macro clocks on clk_i and is disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge outside reset
`define TSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen outside reset
`define TSS_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

@@ rtl/tss_pkg.sv @@
// shared types, widths and codes of the text screen scroll engine
// no dependencies
`default_nettype none

package tss_pkg;

  localparam int unsigned DEF_SCREEN_WIDTH  = 80;
  localparam int unsigned DEF_SCREEN_HEIGHT = 25;

  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned IDX_W      = 11;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CELL_W     = 2 * BYTE_W;
  localparam int unsigned CUR_OUT_W  = 11;
  localparam int unsigned SCROLL_W   = 7;
  localparam int unsigned COLOR_W    = 4;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned ROW_SPAN   = 2 ** (SCROLL_W - 1);
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [COLOR_W-1:0] FG_RESET = 4'd7;
  localparam logic [COLOR_W-1:0] BG_RESET = 4'd0;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_WRITE  = 2'd0,
    FUNC_READ   = 2'd1,
    FUNC_CURSOR = 2'd2,
    FUNC_SCROLL = 2'd3
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FG = 1'b0,
    CFG_BG = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_FINISH
  } back_state_e;

  // classified command header handed from front to back
  typedef struct packed {
    func_e func;
    logic  idx_ok;
  } cmd_ctrl_t;

  // cell address width for a given screen
  function automatic int unsigned cell_aw(input int unsigned w, input int unsigned h);
    return $clog2(w * h);
  endfunction

  // signed width holding row offsets, walker source indexes and cursor sums
  function automatic int unsigned span_w(input int unsigned w);
    return $clog2(ROW_SPAN * w) + 2;
  endfunction

endpackage

`default_nettype wire

@@ rtl/tss_front.sv @@
// front end: accepts items, range checks them and forms commands
// depends on tss_pkg
`default_nettype none

module tss_front
  import tss_pkg::*;
#(
  parameter int unsigned SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int unsigned SCREEN_HEIGHT = DEF_SCREEN_HEIGHT,
  localparam int unsigned CELL_COUNT = SCREEN_WIDTH * SCREEN_HEIGHT,
  localparam int unsigned CELL_AW    = cell_aw(SCREEN_WIDTH, SCREEN_HEIGHT),
  localparam int unsigned SPAN_W     = span_w(SCREEN_WIDTH)
) (
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [FUNC_W-1:0]          func_i,
  input  logic [IDX_W-1:0]           cell_index_i,
  input  logic [BYTE_W-1:0]          cell_char_i,
  input  logic [BYTE_W-1:0]          cell_attr_i,
  input  logic [IDX_W-1:0]           new_cursor_i,
  input  logic signed [SCROLL_W-1:0] scroll_rows_i,
  input  logic                       q_full_i,
  output logic                       push_o,
  output cmd_ctrl_t                  ctrl_o,
  output logic [CELL_AW-1:0]         addr_o,
  output logic [CELL_W-1:0]          wdata_o,
  output logic [CELL_AW-1:0]         curs_o,
  output logic signed [SPAN_W-1:0]   off_o
);

  localparam logic signed [SPAN_W-1:0] WIDTH_S = SPAN_W'(SCREEN_WIDTH);

  logic signed [SPAN_W-1:0] rows_s;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  assign ctrl_o.func   = func_e'(func_i);
  assign ctrl_o.idx_ok = 32'(cell_index_i) < 32'(CELL_COUNT);

  assign addr_o  = CELL_AW'(cell_index_i);
  assign wdata_o = {cell_attr_i, cell_char_i};

  // out of range cursor saturates to the last cell
  assign curs_o = (32'(new_cursor_i) < 32'(CELL_COUNT)) ? CELL_AW'(new_cursor_i)
                                                        : CELL_AW'(CELL_COUNT - 1);

  // row count times width, the linear cell offset of a scroll
  assign rows_s = {{(SPAN_W - SCROLL_W){scroll_rows_i[SCROLL_W-1]}}, scroll_rows_i};
  assign off_o  = rows_s * WIDTH_S;

endmodule

`default_nettype wire

@@ rtl/tss_cmd_queue.sv @@
// small command queue between front and back
// depends on tss_pkg
`default_nettype none

module tss_cmd_queue
  import tss_pkg::*;
#(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] pop_data_i_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o       = cnt_q == CNT_W'(DEPTH);
  assign valid_o      = cnt_q != '0;
  assign pop_data_i_o = entry_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/tss_back.sv @@
// back end: cell store, scroll walker, cursor and result register
// depends on tss_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module tss_back
  import tss_pkg::*;
#(
  parameter int unsigned SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int unsigned SCREEN_HEIGHT = DEF_SCREEN_HEIGHT,
  localparam int unsigned CELL_COUNT = SCREEN_WIDTH * SCREEN_HEIGHT,
  localparam int unsigned CELL_AW    = cell_aw(SCREEN_WIDTH, SCREEN_HEIGHT),
  localparam int unsigned SPAN_W     = span_w(SCREEN_WIDTH)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cmd_valid_i,
  output logic                     cmd_pop_o,
  input  cmd_ctrl_t                ctrl_i,
  input  logic [CELL_AW-1:0]       addr_i,
  input  logic [CELL_W-1:0]        wdata_i,
  input  logic [CELL_AW-1:0]       curs_i,
  input  logic signed [SPAN_W-1:0] off_i,
  input  logic [BYTE_W-1:0]        blank_attr_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [BYTE_W-1:0]        read_char_o,
  output logic [BYTE_W-1:0]        read_attr_o,
  output logic [CUR_OUT_W-1:0]     cursor_pos_o
);

  localparam logic signed [SPAN_W-1:0] CELL_S      = SPAN_W'(CELL_COUNT);
  localparam logic signed [SPAN_W-1:0] CELL_LAST_S = SPAN_W'(CELL_COUNT - 1);
  localparam logic signed [SPAN_W-1:0] ONE_S       = SPAN_W'(1);
  localparam logic [CELL_AW-1:0]       LAST_ROW    =
    CELL_AW'(SCREEN_WIDTH * (SCREEN_HEIGHT - 1));
  localparam logic [CELL_AW-1:0]       LAST_CELL   = CELL_AW'(CELL_COUNT - 1);

  back_state_e state_q, state_d;

  logic [CELL_W-1:0] cell_mem [CELL_COUNT];
  logic [CELL_W-1:0] rd_data_q;
  logic              rd_en;
  logic [CELL_AW-1:0] rd_addr;
  logic              mem_we;
  logic [CELL_AW-1:0] mem_waddr;
  logic [CELL_W-1:0] mem_wdata;

  logic [CELL_AW-1:0]       dst_q, dst_d;
  logic signed [SPAN_W-1:0] src_q, src_d;
  logic                     up_q, up_d;
  logic                     wr_pend_q, wr_pend_d;
  logic [CELL_AW-1:0]       wr_addr_q, wr_addr_d;
  logic                     wr_mem_q, wr_mem_d;

  logic [CELL_AW-1:0]   cursor_q, cursor_d;
  logic                 res_valid_q, res_valid_d;
  logic [BYTE_W-1:0]    res_char_q, res_char_d;
  logic [BYTE_W-1:0]    res_attr_q, res_attr_d;
  logic [CUR_OUT_W-1:0] res_cursor_q, res_cursor_d;

  logic                     res_free;
  logic                     src_ok;
  logic                     walk_last;
  logic signed [SPAN_W-1:0] cur_s;
  logic signed [SPAN_W-1:0] moved_s;
  logic [CELL_AW-1:0]       scroll_cur;
  logic                     cmd_pop;

  assign res_free  = !res_valid_q || !out_stall_i;
  assign src_ok    = !src_q[SPAN_W-1] && (src_q < CELL_S);
  assign walk_last = up_q ? (dst_q == LAST_CELL) : (dst_q == '0);

  // cursor after a scroll, clamped at both ends
  assign cur_s   = $signed({{(SPAN_W - CELL_AW){1'b0}}, cursor_q});
  assign moved_s = cur_s - off_i;
  always_comb begin
    if (moved_s <= ONE_S) begin
      scroll_cur = '0;
    end else if (moved_s >= CELL_S) begin
      scroll_cur = LAST_ROW;
    end else begin
      scroll_cur = moved_s[CELL_AW-1:0];
    end
  end

  always_comb begin
    state_d      = state_q;
    dst_d        = dst_q;
    src_d        = src_q;
    up_d         = up_q;
    wr_pend_d    = 1'b0;
    wr_addr_d    = wr_addr_q;
    wr_mem_d     = wr_mem_q;
    cursor_d     = cursor_q;
    res_valid_d  = res_valid_q && out_stall_i;
    res_char_d   = res_char_q;
    res_attr_d   = res_attr_q;
    res_cursor_d = res_cursor_q;
    cmd_pop      = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = addr_i;
    // walker writes land in the cycle after their source read
    mem_we       = wr_pend_q;
    mem_waddr    = wr_addr_q;
    mem_wdata    = wr_mem_q ? rd_data_q : {blank_attr_i, BYTE_W'(0)};

    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && res_free) begin
          case (ctrl_i.func)
            FUNC_WRITE: begin
              cmd_pop      = 1'b1;
              mem_we       = ctrl_i.idx_ok;
              mem_waddr    = addr_i;
              mem_wdata    = wdata_i;
              res_valid_d  = 1'b1;
              res_char_d   = '0;
              res_attr_d   = '0;
              res_cursor_d = CUR_OUT_W'(cursor_q);
            end
            FUNC_READ: begin
              // command stays at the queue head until the data is back
              rd_en   = 1'b1;
              state_d = ST_READ;
            end
            FUNC_CURSOR: begin
              cmd_pop      = 1'b1;
              cursor_d     = curs_i;
              res_valid_d  = 1'b1;
              res_char_d   = '0;
              res_attr_d   = '0;
              res_cursor_d = CUR_OUT_W'(curs_i);
            end
            FUNC_SCROLL: begin
              cmd_pop  = 1'b1;
              cursor_d = scroll_cur;
              if (off_i == '0) begin
                res_valid_d  = 1'b1;
                res_char_d   = '0;
                res_attr_d   = '0;
                res_cursor_d = CUR_OUT_W'(scroll_cur);
              end else begin
                up_d    = !off_i[SPAN_W-1];
                state_d = ST_SCROLL;
                if (!off_i[SPAN_W-1]) begin
                  dst_d = '0;
                  src_d = off_i;
                end else begin
                  dst_d = LAST_CELL;
                  src_d = off_i + CELL_LAST_S;
                end
              end
            end
            default: begin
              cmd_pop = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        if (res_free) begin
          cmd_pop      = 1'b1;
          res_valid_d  = 1'b1;
          res_char_d   = ctrl_i.idx_ok ? rd_data_q[BYTE_W-1:0] : '0;
          res_attr_d   = ctrl_i.idx_ok ? rd_data_q[CELL_W-1:BYTE_W] : '0;
          res_cursor_d = CUR_OUT_W'(cursor_q);
          state_d      = ST_IDLE;
        end
      end
      ST_SCROLL: begin
        rd_en     = src_ok;
        rd_addr   = src_q[CELL_AW-1:0];
        wr_pend_d = 1'b1;
        wr_addr_d = dst_q;
        wr_mem_d  = src_ok;
        if (walk_last) begin
          state_d = ST_FINISH;
        end else if (up_q) begin
          dst_d = dst_q + 1'b1;
          src_d = src_q + ONE_S;
        end else begin
          dst_d = dst_q - 1'b1;
          src_d = src_q - ONE_S;
        end
      end
      ST_FINISH: begin
        if (res_free) begin
          res_valid_d  = 1'b1;
          res_char_d   = '0;
          res_attr_d   = '0;
          res_cursor_d = CUR_OUT_W'(cursor_q);
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wr_pend_q   <= 1'b0;
      cursor_q    <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wr_pend_q   <= wr_pend_d;
      cursor_q    <= cursor_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dst_q        <= dst_d;
    src_q        <= src_d;
    up_q         <= up_d;
    wr_addr_q    <= wr_addr_d;
    wr_mem_q     <= wr_mem_d;
    res_char_q   <= res_char_d;
    res_attr_q   <= res_attr_d;
    res_cursor_q <= res_cursor_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cell_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= cell_mem[rd_addr];
    end
  end

  assign cmd_pop_o    = cmd_pop;
  assign out_valid_o  = res_valid_q;
  assign read_char_o  = res_char_q;
  assign read_attr_o  = res_attr_q;
  assign cursor_pos_o = res_cursor_q;

  `TSS_ASSERT(a_pend_in_walk, wr_pend_q |-> (state_q == ST_SCROLL || state_q == ST_FINISH), "walker write outside a scroll")
  `TSS_NEVER(a_rw_clash, wr_pend_q && rd_en && (rd_addr == wr_addr_q), "scroll reads a cell being written")
  `TSS_ASSERT(a_cursor_range, 32'(cursor_q) < 32'(CELL_COUNT), "cursor beyond the screen")
  `TSS_ASSERT(a_pop_has_slot, cmd_pop |-> res_free, "command retired with result register busy")

endmodule

`default_nettype wire

@@ rtl/text_screen_scroll_engine.sv @@
// text screen scroll engine, top level
// the input channel takes one command per transfer: write cell, read cell,
// set cursor or scroll by a signed row count; every command gives exactly
// one result transfer with read data (zero unless a read) and the cursor
// a front end range checks commands and forms the scroll offset, a
// two-entry queue decouples it from the back end, which owns the cell
// store, the cursor and the result register
// in the back end, write cell, set cursor and a zero-row scroll retire from
// idle, read cell waits for its registered store read, and any other scroll
// walks all WIDTH*HEIGHT cells: the walker moves one cell a cycle through the
// store's single read and single write port
// the input stalls only when the queue is full; a stalled result holds in
// the output register while the back end keeps working until it needs
// to retire the next command
// reset clears the cursor, loads fg 7 and bg 0 and empties the queue; the
// cell store is not cleared and must be written before it is read
// configuration writes are always taken and belong to idle periods
// depends on tss_pkg, tss_front, tss_cmd_queue, tss_back
`default_nettype none

module text_screen_scroll_engine
  import tss_pkg::*;
#(
  parameter int unsigned SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int unsigned SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // command input channel
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [FUNC_W-1:0]          func_i,
  input  logic [IDX_W-1:0]           cell_index_i,
  input  logic [BYTE_W-1:0]          cell_char_i,
  input  logic [BYTE_W-1:0]          cell_attr_i,
  input  logic [IDX_W-1:0]           new_cursor_i,
  input  logic signed [SCROLL_W-1:0] scroll_rows_i,
  // result channel
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [BYTE_W-1:0]          read_char_o,
  output logic [BYTE_W-1:0]          read_attr_o,
  output logic [CUR_OUT_W-1:0]       cursor_pos_o,
  // register write channel
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [COLOR_W-1:0]         cfg_data_i
);

  localparam int unsigned CELL_AW = cell_aw(SCREEN_WIDTH, SCREEN_HEIGHT);
  localparam int unsigned SPAN_W  = span_w(SCREEN_WIDTH);
  localparam int unsigned CTRL_W  = $bits(cmd_ctrl_t);
  localparam int unsigned CMD_W   = CTRL_W + CELL_AW + CELL_W + CELL_AW + SPAN_W;

  // blank colour registers
  logic [COLOR_W-1:0] fg_q, fg_d;
  logic [COLOR_W-1:0] bg_q, bg_d;

  // front side of the queue
  logic                     push;
  logic                     q_full;
  cmd_ctrl_t                f_ctrl;
  logic [CELL_AW-1:0]       f_addr;
  logic [CELL_W-1:0]        f_wdata;
  logic [CELL_AW-1:0]       f_curs;
  logic signed [SPAN_W-1:0] f_off;
  logic [CMD_W-1:0]         push_data;

  // back side of the queue
  logic                     q_valid;
  logic                     pop;
  logic [CMD_W-1:0]         pop_data;
  cmd_ctrl_t                b_ctrl;
  logic [CELL_AW-1:0]       b_addr;
  logic [CELL_W-1:0]        b_wdata;
  logic [CELL_AW-1:0]       b_curs;
  logic signed [SPAN_W-1:0] b_off;

  // registers take every transfer
  assign cfg_ready_o = 1'b1;

  always_comb begin
    fg_d = fg_q;
    bg_d = bg_q;
    if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_FG:  fg_d = cfg_data_i;
        CFG_BG:  bg_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q <= FG_RESET;
      bg_q <= BG_RESET;
    end else begin
      fg_q <= fg_d;
      bg_q <= bg_d;
    end
  end

  tss_front #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_front (
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .cell_index_i  (cell_index_i),
    .cell_char_i   (cell_char_i),
    .cell_attr_i   (cell_attr_i),
    .new_cursor_i  (new_cursor_i),
    .scroll_rows_i (scroll_rows_i),
    .q_full_i      (q_full),
    .push_o        (push),
    .ctrl_o        (f_ctrl),
    .addr_o        (f_addr),
    .wdata_o       (f_wdata),
    .curs_o        (f_curs),
    .off_o         (f_off)
  );

  assign push_data = {f_ctrl, f_addr, f_wdata, f_curs, f_off};

  tss_cmd_queue #(
    .WIDTH (CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .full_o       (q_full),
    .pop_i        (pop),
    .valid_o      (q_valid),
    .pop_data_i_o (pop_data)
  );

  assign {b_ctrl, b_addr, b_wdata, b_curs, b_off} = pop_data;

  tss_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (q_valid),
    .cmd_pop_o    (pop),
    .ctrl_i       (b_ctrl),
    .addr_i       (b_addr),
    .wdata_i      (b_wdata),
    .curs_i       (b_curs),
    .off_i        (b_off),
    .blank_attr_i ({fg_q, bg_q}),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .read_char_o  (read_char_o),
    .read_attr_o  (read_attr_o),
    .cursor_pos_o (cursor_pos_o)
  );

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// self-checking bench for the text screen scroll engine: directed table, then random phases
// needs tss_pkg and the rtl of text_screen_scroll_engine, nothing else
`default_nettype none

module testbench;
  import tss_pkg::*;

  // screen geometry of the default build
  localparam int SCREEN_W = DEF_SCREEN_WIDTH;
  localparam int SCREEN_H = DEF_SCREEN_HEIGHT;
  localparam int CELLS    = SCREEN_W * SCREEN_H;
  localparam int IDX_MAX  = 2 ** IDX_W - 1;

  // a scroll walks every cell without a transfer, so the limit must cover a whole walk
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 50;
  localparam int RAND_PHASES    = 4;
  localparam int RAND_PER_PHASE = 31;
  localparam int RECENT_DEPTH   = 16;
  localparam int DIR_N          = 30;

  // one command as it goes over the input channel
  typedef struct packed {
    func_e                func;
    logic [IDX_W-1:0]     idx;
    logic [BYTE_W-1:0]    ch;
    logic [BYTE_W-1:0]    at;
    logic [IDX_W-1:0]     ncur;
    logic [SCROLL_W-1:0]  rows;
  } scr_cmd_t;

  // one result transfer
  typedef struct packed {
    logic [BYTE_W-1:0]    rc;
    logic [BYTE_W-1:0]    ra;
    logic [CUR_OUT_W-1:0] cur;
  } scr_res_t;

  typedef enum bit {ROW_CMD, ROW_CFG} row_kind_e;

  // directed row; a color row carries fg in ch and bg in at
  typedef struct packed {
    row_kind_e            kind;
    func_e                func;
    logic [IDX_W-1:0]     idx;
    logic [BYTE_W-1:0]    ch;
    logic [BYTE_W-1:0]    at;
    logic [IDX_W-1:0]     ncur;
    logic [SCROLL_W-1:0]  rows;
    bit                   chk;
    logic [BYTE_W-1:0]    rc;
    logic [BYTE_W-1:0]    ra;
    logic [CUR_OUT_W-1:0] cur;
  } dir_row_t;

  // rows with chk set carry their result typed in, the rest go to the predictor
  dir_row_t dir_tab [DIR_N] = '{
    // zero scroll right after reset, cursor stays at 0
    '{ROW_CMD, FUNC_SCROLL, '0, '0, '0, '0, '0, 1'b1, '0, '0, '0},
    // largest up scroll blanks the whole screen, cursor clamps to 0
    '{ROW_CMD, FUNC_SCROLL, '0, '0, '0, '0, 7'sd63, 1'b1, '0, '0, '0},
    // blank cell with reset colors: fg 7, bg 0
    '{ROW_CMD, FUNC_READ, '0, '0, '0, '0, '0, 1'b1, 8'h00, 8'h70, '0},
    '{ROW_CMD, FUNC_WRITE, '0, 8'hff, 8'hff, '0, '0, 1'b1, '0, '0, '0},
    '{ROW_CMD, FUNC_WRITE, 11'd1999, 8'h5a, 8'ha5, '0, '0, 1'b1, '0, '0, '0},
    // index past the screen: the write is dropped, the read gives zero
    '{ROW_CMD, FUNC_WRITE, 11'd2047, 8'hff, 8'hff, '0, '0, 1'b1, '0, '0, '0},
    '{ROW_CMD, FUNC_READ, 11'd2047, '0, '0, '0, '0, 1'b1, '0, '0, '0},
    '{ROW_CMD, FUNC_READ, 11'd1999, '0, '0, '0, '0, 1'b1, 8'h5a, 8'ha5, '0},
    '{ROW_CMD, FUNC_READ, '0, '0, '0, '0, '0, 1'b1, 8'hff, 8'hff, '0},
    // cursor past the screen saturates at the last cell
    '{ROW_CMD, FUNC_CURSOR, '0, '0, '0, 11'd2047, '0, 1'b1, '0, '0, 11'd1999},
    // cursor of 1 followed by a zero scroll drops to 0
    '{ROW_CMD, FUNC_CURSOR, '0, '0, '0, 11'd1, '0, 1'b1, '0, '0, 11'd1},
    '{ROW_CMD, FUNC_SCROLL, '0, '0, '0, '0, '0, 1'b1, '0, '0, '0},
    // scrolling down from the last cell clamps to the start of the last row
    '{ROW_CMD, FUNC_CURSOR, '0, '0, '0, 11'd1999, '0, 1'b1, '0, '0, 11'd1999},
    '{ROW_CMD, FUNC_SCROLL, '0, '0, '0, '0, -7'sd1, 1'b1, '0, '0, 11'd1920},
    '{ROW_CMD, FUNC_READ, 11'd79, '0, '0, '0, '0, 1'b1, 8'h00, 8'h70, 11'd1920},
    // blank colors at the top extreme, then the most negative count (-64)
    '{ROW_CFG, FUNC_WRITE, '0, 8'h0f, 8'h0f, '0, '0, 1'b0, '0, '0, '0},
    '{ROW_CMD, FUNC_SCROLL, '0, '0, '0, '0, 7'h40, 1'b1, '0, '0, 11'd1920},
    '{ROW_CMD, FUNC_READ, '0, '0, '0, '0, '0, 1'b1, 8'h00, 8'hff, 11'd1920},
    // blank colors at the bottom extreme, count of exactly the screen height
    '{ROW_CFG, FUNC_WRITE, '0, '0, '0, '0, '0, 1'b0, '0, '0, '0},
    '{ROW_CMD, FUNC_SCROLL, '0, '0, '0, '0, 7'sd25, 1'b1, '0, '0, '0},
    // content carried by partial scrolls both ways
    '{ROW_CMD, FUNC_WRITE, 11'd80, 8'h11, 8'h22, '0, '0, 1'b0, '0, '0, '0},
    '{ROW_CMD, FUNC_WRITE, 11'd1920, 8'h33, 8'h44, '0, '0, 1'b0, '0, '0, '0},
    '{ROW_CMD, FUNC_CURSOR, '0, '0, '0, 11'd1000, '0, 1'b0, '0, '0, '0},
    '{ROW_CMD, FUNC_SCROLL, '0, '0, '0, '0, 7'sd1, 1'b0, '0, '0, '0},
    '{ROW_CMD, FUNC_READ, '0, '0, '0, '0, '0, 1'b0, '0, '0, '0},
    '{ROW_CMD, FUNC_READ, 11'd1840, '0, '0, '0, '0, 1'b0, '0, '0, '0},
    '{ROW_CMD, FUNC_SCROLL, '0, '0, '0, '0, -7'sd24, 1'b0, '0, '0, '0},
    '{ROW_CMD, FUNC_SCROLL, '0, '0, '0, '0, 7'sd24, 1'b0, '0, '0, '0},
    '{ROW_CMD, FUNC_READ, '0, '0, '0, '0, '0, 1'b0, '0, '0, '0},
    '{ROW_CMD, FUNC_SCROLL, '0, '0, '0, '0, -7'sd25, 1'b0, '0, '0, '0}
  };

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // dut inputs, all known from time zero
  logic                 in_valid  = 1'b0;
  func_e                drv_func  = FUNC_WRITE;
  logic [IDX_W-1:0]     drv_idx   = '0;
  logic [BYTE_W-1:0]    drv_char  = '0;
  logic [BYTE_W-1:0]    drv_attr  = '0;
  logic [IDX_W-1:0]     drv_ncur  = '0;
  logic [SCROLL_W-1:0]  drv_rows  = '0;
  logic                 out_stall = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COLOR_W-1:0]   cfg_data  = '0;

  // dut outputs
  wire                  in_stall;
  wire                  out_valid;
  wire [BYTE_W-1:0]     read_char;
  wire [BYTE_W-1:0]     read_attr;
  wire [CUR_OUT_W-1:0]  cursor_pos;
  wire                  cfg_ready;

  text_screen_scroll_engine dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .func_i        (drv_func),
    .cell_index_i  (drv_idx),
    .cell_char_i   (drv_char),
    .cell_attr_i   (drv_attr),
    .new_cursor_i  (drv_ncur),
    .scroll_rows_i (drv_rows),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .read_char_o   (read_char),
    .read_attr_o   (read_attr),
    .cursor_pos_o  (cursor_pos),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  // shadow screen: cell contents, which cells hold defined data, cursor, colors
  logic [CELL_W-1:0]  cell_mem [CELLS];
  bit                 cell_known [CELLS];
  int                 cur_pred = 0;
  logic [COLOR_W-1:0] pred_fg  = FG_RESET;
  logic [COLOR_W-1:0] pred_bg  = BG_RESET;

  // results still owed by the dut, oldest first
  scr_res_t pend_q [$];
  // recently written cells, so random reads hit live content
  logic [IDX_W-1:0] recent_idx [$];

  bit idle_on     = 1'b1;
  int stall_left  = 0;
  int idle_cycles = 0;
  int err_count   = 0;
  int n_cmds      = 0;
  int n_reads     = 0;
  int n_scrolls   = 0;
  int n_cfg       = 0;
  int n_results   = 0;

  // apply one command to the shadow screen and return what the dut should answer
  function automatic scr_res_t screen_step(input scr_cmd_t c);
    scr_res_t r;
    logic [CELL_W-1:0] blank;
    int n;
    int k;
    int j;
    int dst;
    int src;
    int t;
    r = '0;
    case (c.func)
      FUNC_WRITE: begin
        if (c.idx < CELLS) begin
          cell_mem[c.idx]   = {c.at, c.ch};
          cell_known[c.idx] = 1'b1;
        end
      end
      FUNC_READ: begin
        if (c.idx < CELLS) begin
          r.rc = cell_mem[c.idx][BYTE_W-1:0];
          r.ra = cell_mem[c.idx][CELL_W-1:BYTE_W];
        end
      end
      FUNC_CURSOR: cur_pred = (c.ncur < CELLS) ? int'(c.ncur) : CELLS - 1;
      default: begin
        n = int'($signed(c.rows));
        blank = {pred_fg, pred_bg, 8'h00};
        if (n != 0) begin
          // walk rows in the direction that never reads an overwritten row
          for (k = 0; k < SCREEN_H; k++) begin
            dst = (n > 0) ? k : SCREEN_H - 1 - k;
            src = dst + n;
            for (j = 0; j < SCREEN_W; j++) begin
              if (src >= 0 && src < SCREEN_H) begin
                cell_mem[dst * SCREEN_W + j]   = cell_mem[src * SCREEN_W + j];
                cell_known[dst * SCREEN_W + j] = cell_known[src * SCREEN_W + j];
              end else begin
                cell_mem[dst * SCREEN_W + j]   = blank;
                cell_known[dst * SCREEN_W + j] = 1'b1;
              end
            end
          end
        end
        // cursor follows the content, clamped at both ends
        t = cur_pred - n * SCREEN_W;
        if (t <= 1) cur_pred = 0;
        else if (t >= CELLS) cur_pred = SCREEN_W * (SCREEN_H - 1);
        else cur_pred = t;
      end
    endcase
    r.cur = CUR_OUT_W'(cur_pred);
    return r;
  endfunction

  // random command, never a read of a cell without defined content
  function automatic scr_cmd_t rand_cmd();
    scr_cmd_t c;
    int sel;
    // unused fields carry noise
    c.idx  = IDX_W'($urandom_range(0, IDX_MAX));
    c.ch   = BYTE_W'($urandom);
    c.at   = BYTE_W'($urandom);
    c.ncur = IDX_W'($urandom_range(0, IDX_MAX));
    c.rows = SCROLL_W'($urandom);
    sel = $urandom_range(0, 99);
    if (sel < 35) begin
      c.func = FUNC_WRITE;
      if ($urandom_range(0, 9) != 0) c.idx = IDX_W'($urandom_range(0, CELLS - 1));
    end else if (sel < 65) begin
      c.func = FUNC_READ;
      if ($urandom_range(0, 9) == 0) begin
        c.idx = IDX_W'($urandom_range(CELLS, IDX_MAX));
      end else if (recent_idx.size() != 0 && $urandom_range(0, 1) == 1) begin
        c.idx = recent_idx[$urandom_range(0, recent_idx.size() - 1)];
      end else begin
        c.idx = IDX_W'($urandom_range(0, CELLS - 1));
      end
      // undefined content must not be read: write it instead
      if (c.idx < CELLS && !cell_known[c.idx]) c.func = FUNC_WRITE;
    end else if (sel < 75) begin
      c.func = FUNC_CURSOR;
    end else begin
      c.func = FUNC_SCROLL;
      sel = $urandom_range(0, 9);
      // mostly short scrolls, some around the screen height, rest full range
      if (sel < 6) c.rows = SCROLL_W'(int'($urandom_range(0, 6)) - 3);
      else if (sel < 9) c.rows = SCROLL_W'(int'($urandom_range(0, 52)) - 26);
    end
    if (c.func == FUNC_WRITE && c.idx < CELLS) begin
      recent_idx.push_back(c.idx);
      if (recent_idx.size() > RECENT_DEPTH) void'(recent_idx.pop_front());
    end
    return c;
  endfunction

  // offer one command, return at the edge where its transfer happens;
  // valid stays high so a following command can go out back to back
  task automatic push_cmd(input scr_cmd_t c, input bit typed, input scr_res_t typed_res);
    scr_res_t r;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    drv_func <= c.func;
    drv_idx  <= c.idx;
    drv_char <= c.ch;
    drv_attr <= c.at;
    drv_ncur <= c.ncur;
    drv_rows <= c.rows;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    r = screen_step(c);
    pend_q.push_back(typed ? typed_res : r);
    n_cmds++;
    if (c.func == FUNC_READ) n_reads++;
    if (c.func == FUNC_SCROLL) n_scrolls++;
  endtask

  // hold the sender off until every owed result has come back
  task automatic wait_results_done();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pend_q.size() != 0);
  endtask

  // both color registers, written only once the engine has gone idle
  task automatic write_colors(input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg);
    wait_results_done();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_FG;
    cfg_data  <= fg;
    do @(posedge clk_i); while (!cfg_ready);
    pred_fg = fg;
    cfg_index <= CFG_BG;
    cfg_data  <= bg;
    do @(posedge clk_i); while (!cfg_ready);
    pred_bg = bg;
    cfg_valid <= 1'b0;
    n_cfg += 2;
  endtask

  // result checker, receiver stall bursts and the activity counter
  always @(posedge clk_i) begin
    scr_res_t want;
    if (rst_ni) begin
      // any transfer on any channel counts as progress
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end

      if (out_valid && !out_stall) begin
        n_results++;
        if (pend_q.size() == 0) begin
          $display("%0t: unexpected result char %02h attr %02h cursor %0d",
                   $time, read_char, read_attr, cursor_pos);
          err_count++;
        end else begin
          want = pend_q.pop_front();
          if (read_char !== want.rc) begin
            $display("%0t: read_char expected %02h actual %02h", $time, want.rc, read_char);
            err_count++;
          end
          if (read_attr !== want.ra) begin
            $display("%0t: read_attr expected %02h actual %02h", $time, want.ra, read_attr);
            err_count++;
          end
          if (cursor_pos !== want.cur) begin
            $display("%0t: cursor_pos expected %0d actual %0d", $time, want.cur, cursor_pos);
            err_count++;
          end
        end
      end

      // random receiver stall bursts while idling is on
      if (stall_left == 0 && idle_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 19);
      end
      out_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // watchdog: too long without any transfer ends the run
  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("timeout after %0d cycles without a transfer", WATCHDOG_LIMIT);
    $display("FAIL text_screen_scroll_engine");
    $finish;
  end

  // stimulus
  initial begin
    scr_cmd_t c;
    scr_res_t typed_res;
    int k;
    int ph;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (k = 0; k < DIR_N; k++) begin
      if (dir_tab[k].kind == ROW_CFG) begin
        write_colors(dir_tab[k].ch[COLOR_W-1:0], dir_tab[k].at[COLOR_W-1:0]);
      end else begin
        c = '{dir_tab[k].func, dir_tab[k].idx, dir_tab[k].ch, dir_tab[k].at,
              dir_tab[k].ncur, dir_tab[k].rows};
        typed_res = '{dir_tab[k].rc, dir_tab[k].ra, dir_tab[k].cur};
        push_cmd(c, dir_tab[k].chk, typed_res);
      end
    end

    // random phases, new blank colors each time, last phase without idling
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      write_colors(COLOR_W'($urandom_range(0, 15)), COLOR_W'($urandom_range(0, 15)));
      if (ph == RAND_PHASES - 1) idle_on = 1'b0;
      for (k = 0; k < RAND_PER_PHASE; k++) begin
        // now and then let the engine run dry before the next command
        if ((ph == 0 && k == RAND_PER_PHASE / 2) || $urandom_range(0, 24) == 0) begin
          wait_results_done();
        end
        push_cmd(rand_cmd(), 1'b0, '0);
      end
    end

    // drain, then give stray results a chance to show up
    wait_results_done();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pend_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pend_q.size());
      err_count++;
    end

    $display("ran %0d commands (%0d reads, %0d scrolls) and %0d color register writes",
             n_cmds, n_reads, n_scrolls, n_cfg);
    $display("checked %0d results, %0d mismatches", n_results, err_count);
    if (err_count == 0) begin
      $display("PASS text_screen_scroll_engine");
    end else begin
      $display("FAIL text_screen_scroll_engine");
    end
    $finish;
  end

endmodule

`default_nettype wire
